// ===== design/iokv_pkg.sv =====
// Shared types and constants for the insertion-ordered key-value table.
package iokv_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int RANK_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int REQ_W    = 3;
  localparam int POS_W    = 4;
  localparam int STAT_W   = 3;
  localparam int ECNT_W   = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_ERASE  = 3'd1,
    REQ_POP    = 3'd2,
    REQ_LOOKUP = 3'd3,
    REQ_CLEAR  = 3'd4,
    REQ_READ   = 3'd5
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_UPDATED   = 3'd1,
    STAT_REMOVED   = 3'd2,
    STAT_FOUND     = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_EMPTY     = 3'd5,
    STAT_FULL      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  // Sequencer controls for the slot store
  typedef struct packed {
    logic             load;   // latch the request word
    logic             scan;   // compare slot idx this cycle
    logic             apply;  // write back and issue the result
    logic [IDX_W-1:0] idx;
  } ctl_t;

endpackage

// ===== design/insertion_ordered_key_value_table_unit.sv =====
// Top level of the insertion-ordered key-value table.
// done rises once every slot has been scanned and the writeback state has run.
// Requests do not overlap: a new start is taken only when idle, as early as the cycle done is high.
// The scan steps one slot per cycle through a single shared comparator.
// Synchronous reset empties the table and returns the sequencer to idle.
// The receiver cannot stall: each result shows for one cycle under done.
module insertion_ordered_key_value_table_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic        [iokv_pkg::REQ_W-1:0]   req_type,
  input  logic signed [iokv_pkg::KEY_W-1:0]   key,
  input  logic signed [iokv_pkg::VAL_W-1:0]   value,
  input  logic        [iokv_pkg::POS_W-1:0]   position,
  output logic                                busy,
  output logic                                done,
  output logic        [iokv_pkg::STAT_W-1:0]  status,
  output logic signed [iokv_pkg::KEY_W-1:0]   out_key,
  output logic signed [iokv_pkg::VAL_W-1:0]   out_value,
  output logic        [iokv_pkg::ECNT_W-1:0]  entry_count
);

  iokv_pkg::ctl_t                 ctl;
  logic [iokv_pkg::KEY_W-1:0]     key_u;
  logic [iokv_pkg::VAL_W-1:0]     val_u;
  logic [iokv_pkg::KEY_W-1:0]     okey_u;
  logic [iokv_pkg::VAL_W-1:0]     oval_u;
  logic [iokv_pkg::COUNT_W-1:0]   count;

  assign key_u       = key;
  assign val_u       = value;
  assign out_key     = okey_u;
  assign out_value   = oval_u;
  assign entry_count = iokv_pkg::ECNT_W'(count);

  iokv_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  iokv_store u_store (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .req_type  (req_type),
    .key       (key_u),
    .value     (val_u),
    .position  (position),
    .done      (done),
    .status    (status),
    .out_key   (okey_u),
    .out_value (oval_u),
    .count     (count)
  );

endmodule

// ===== design/iokv_ctrl.sv =====
// Sequencer: walks the slot index for the scan, then enters the writeback state.
module iokv_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output iokv_pkg::ctl_t       ctl
);

  iokv_pkg::state_t            state;
  iokv_pkg::state_t            state_next;
  logic [iokv_pkg::IDX_W-1:0]  cnt;
  logic                        last;

  assign last = (cnt == iokv_pkg::IDX_W'(iokv_pkg::CAPACITY - 1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      iokv_pkg::S_IDLE:  if (start) state_next = iokv_pkg::S_SCAN;
      iokv_pkg::S_SCAN:  if (last) state_next = iokv_pkg::S_APPLY;
      iokv_pkg::S_APPLY: state_next = iokv_pkg::S_IDLE;
      default:           state_next = iokv_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy      = 1'b1;
    ctl.load  = 1'b0;
    ctl.scan  = 1'b0;
    ctl.apply = 1'b0;
    ctl.idx   = cnt;
    case (state)
      iokv_pkg::S_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      iokv_pkg::S_SCAN:  ctl.scan = 1'b1;
      iokv_pkg::S_APPLY: ctl.apply = 1'b1;
      default:           busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iokv_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == iokv_pkg::S_SCAN) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

endmodule

// ===== design/iokv_store.sv =====
// Slot storage, shared scan comparator and per-request writeback.
module iokv_store (
  input  logic                         clk,
  input  logic                         rst,
  input  iokv_pkg::ctl_t               ctl,
  input  logic [iokv_pkg::REQ_W-1:0]   req_type,
  input  logic [iokv_pkg::KEY_W-1:0]   key,
  input  logic [iokv_pkg::VAL_W-1:0]   value,
  input  logic [iokv_pkg::POS_W-1:0]   position,
  output logic                         done,
  output logic [iokv_pkg::STAT_W-1:0]  status,
  output logic [iokv_pkg::KEY_W-1:0]   out_key,
  output logic [iokv_pkg::VAL_W-1:0]   out_value,
  output logic [iokv_pkg::COUNT_W-1:0] count
);

  localparam int N = iokv_pkg::CAPACITY;

  // Slot state
  logic [N-1:0]                 slot_valid;
  logic [iokv_pkg::KEY_W-1:0]   slot_key   [N];
  logic [iokv_pkg::VAL_W-1:0]   slot_value [N];
  logic [iokv_pkg::RANK_W-1:0]  slot_rank  [N];

  // Latched request word
  logic [iokv_pkg::REQ_W-1:0]   req_r;
  logic [iokv_pkg::KEY_W-1:0]   key_r;
  logic [iokv_pkg::VAL_W-1:0]   val_r;
  logic [iokv_pkg::POS_W-1:0]   pos_r;

  // Scan results
  logic                         hit;
  logic [iokv_pkg::IDX_W-1:0]   hit_idx;
  logic [iokv_pkg::RANK_W-1:0]  hit_rank;
  logic                         free_ok;
  logic [iokv_pkg::IDX_W-1:0]   free_idx;

  // Shared comparator operands
  logic                         by_key;
  logic [iokv_pkg::RANK_W-1:0]  target_rank;
  logic [iokv_pkg::KEY_W-1:0]   cmp_a;
  logic [iokv_pkg::KEY_W-1:0]   cmp_b;
  logic                         match;

  assign by_key = req_r inside {iokv_pkg::REQ_INSERT, iokv_pkg::REQ_ERASE,
                                iokv_pkg::REQ_LOOKUP};
  assign target_rank = (req_r == iokv_pkg::REQ_READ) ? iokv_pkg::RANK_W'(pos_r) : '0;

  always_comb begin
    if (by_key) begin
      cmp_a = slot_key[ctl.idx];
      cmp_b = key_r;
    end else begin
      cmp_a = iokv_pkg::KEY_W'(slot_rank[ctl.idx]);
      cmp_b = iokv_pkg::KEY_W'(target_rank);
    end
  end

  assign match = slot_valid[ctl.idx] && (cmp_a == cmp_b);

  // Request latch and scan capture
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r   <= req_type;
      key_r   <= key;
      val_r   <= value;
      pos_r   <= position;
      hit     <= 1'b0;
      free_ok <= 1'b0;
    end else if (ctl.scan) begin
      if (match && !hit) begin
        hit      <= 1'b1;
        hit_idx  <= ctl.idx;
        hit_rank <= slot_rank[ctl.idx];
      end
      if (!slot_valid[ctl.idx] && !free_ok) begin
        free_ok  <= 1'b1;
        free_idx <= ctl.idx;
      end
    end
  end

  // Writeback and result
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      count      <= '0;
      done       <= 1'b0;
    end else begin
      done <= ctl.apply;
      if (ctl.apply) begin
        case (req_r)
          iokv_pkg::REQ_INSERT: begin
            out_key   <= '0;
            out_value <= '0;
            if (hit) begin
              slot_value[hit_idx] <= val_r;
              for (int i = 0; i < N; i++) begin
                if (iokv_pkg::IDX_W'(i) == hit_idx) begin
                  slot_rank[i] <= iokv_pkg::RANK_W'(count - 1'b1);
                end else if (slot_valid[i] && slot_rank[i] > hit_rank) begin
                  slot_rank[i] <= slot_rank[i] - 1'b1;
                end
              end
              status <= iokv_pkg::STAT_UPDATED;
            end else if (count >= iokv_pkg::COUNT_W'(N) || !free_ok) begin
              status <= iokv_pkg::STAT_FULL;
            end else begin
              slot_valid[free_idx] <= 1'b1;
              slot_key[free_idx]   <= key_r;
              slot_value[free_idx] <= val_r;
              slot_rank[free_idx]  <= iokv_pkg::RANK_W'(count);
              count                <= count + 1'b1;
              status               <= iokv_pkg::STAT_INSERTED;
            end
          end
          iokv_pkg::REQ_ERASE, iokv_pkg::REQ_POP: begin
            if (hit && count != '0) begin
              out_key              <= slot_key[hit_idx];
              out_value            <= slot_value[hit_idx];
              slot_valid[hit_idx]  <= 1'b0;
              for (int i = 0; i < N; i++) begin
                if (slot_valid[i] && slot_rank[i] > hit_rank) begin
                  slot_rank[i] <= slot_rank[i] - 1'b1;
                end
              end
              count  <= count - 1'b1;
              status <= iokv_pkg::STAT_REMOVED;
            end else begin
              out_key   <= '0;
              out_value <= '0;
              status    <= (req_r == iokv_pkg::REQ_POP) ? iokv_pkg::STAT_EMPTY
                                                        : iokv_pkg::STAT_NOT_FOUND;
            end
          end
          iokv_pkg::REQ_LOOKUP: begin
            if (hit) begin
              out_key   <= slot_key[hit_idx];
              out_value <= slot_value[hit_idx];
              status    <= iokv_pkg::STAT_FOUND;
            end else begin
              out_key   <= '0;
              out_value <= '0;
              status    <= iokv_pkg::STAT_NOT_FOUND;
            end
          end
          iokv_pkg::REQ_CLEAR: begin
            slot_valid <= '0;
            count      <= '0;
            out_key    <= '0;
            out_value  <= '0;
            status     <= iokv_pkg::STAT_REMOVED;
          end
          iokv_pkg::REQ_READ: begin
            if (hit && iokv_pkg::COUNT_W'(pos_r) < count) begin
              out_key   <= slot_key[hit_idx];
              out_value <= slot_value[hit_idx];
              status    <= iokv_pkg::STAT_FOUND;
            end else begin
              out_key   <= '0;
              out_value <= '0;
              status    <= iokv_pkg::STAT_NOT_FOUND;
            end
          end
          default: begin
            out_key   <= '0;
            out_value <= '0;
            status    <= iokv_pkg::STAT_NOT_FOUND;
          end
        endcase
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the insertion-ordered key-value table unit.
module testbench;
  import iokv_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 24;
  localparam int KEY_POOL_N   = 24;
  localparam int RANDOM_WORDS = 1320;

  // Request codes the table ignores
  localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd7;

  typedef struct {
    logic [REQ_W-1:0]        req;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0]        pos;
    int                      gap;
  } req_word_t;

  typedef struct {
    logic [STAT_W-1:0]       status;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] val;
    logic [ECNT_W-1:0]       count;
  } reply_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [REQ_W-1:0] req_type = '0;
  logic signed [KEY_W-1:0] key = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic [POS_W-1:0] position = '0;
  logic busy;
  logic done;
  logic [STAT_W-1:0] status;
  logic signed [KEY_W-1:0] out_key;
  logic signed [VAL_W-1:0] out_value;
  logic [ECNT_W-1:0] entry_count;

  insertion_ordered_key_value_table_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .req_type(req_type),
    .key(key),
    .value(value),
    .position(position),
    .busy(busy),
    .done(done),
    .status(status),
    .out_key(out_key),
    .out_value(out_value),
    .entry_count(entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the slot store
  logic                    shadow_valid [CAPACITY];
  logic signed [KEY_W-1:0] shadow_key   [CAPACITY];
  logic signed [VAL_W-1:0] shadow_val   [CAPACITY];
  logic [RANK_W-1:0]       shadow_rank  [CAPACITY];
  int                      shadow_count = 0;

  req_word_t   pending_words [$];
  reply_word_t expected_replies [$];
  logic signed [KEY_W-1:0] key_pool [KEY_POOL_N];

  int  cycle_count = 0;
  int  idle_cycles = 0;
  int  words_queued = 0;
  int  words_accepted = 0;
  int  replies_checked = 0;
  int  errors = 0;
  int  full_seen = 0;
  int  updated_seen = 0;
  int  found_seen = 0;
  int  empty_seen = 0;
  bit  burst_mode = 1'b0;

  function automatic int find_key_slot(input logic signed [KEY_W-1:0] k);
    for (int i = 0; i < CAPACITY; i++)
      if (shadow_valid[i] && shadow_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int find_rank_slot(input int r);
    for (int i = 0; i < CAPACITY; i++)
      if (shadow_valid[i] && int'(shadow_rank[i]) == r) return i;
    return -1;
  endfunction

  // Every entry younger than rank r moves one step older
  function automatic void close_rank_gap(input logic [RANK_W-1:0] r);
    for (int i = 0; i < CAPACITY; i++)
      if (shadow_valid[i] && shadow_rank[i] > r) shadow_rank[i]--;
  endfunction

  function automatic void drop_slot(input int s);
    shadow_valid[s] = 1'b0;
    close_rank_gap(shadow_rank[s]);
    shadow_count--;
  endfunction

  // Apply one accepted request to the shadow table and queue its reply
  function automatic void apply_to_shadow(input logic [REQ_W-1:0] req,
                                          input logic signed [KEY_W-1:0] k,
                                          input logic signed [VAL_W-1:0] v,
                                          input logic [POS_W-1:0] pos);
    reply_word_t r;
    int hit;
    int slot;
    r.status = STAT_NOT_FOUND;
    r.key = '0;
    r.val = '0;
    hit = find_key_slot(k);
    case (req)
      REQ_INSERT: begin
        if (hit >= 0) begin
          shadow_val[hit] = v;
          close_rank_gap(shadow_rank[hit]);
          shadow_rank[hit] = RANK_W'(shadow_count - 1);
          r.status = STAT_UPDATED;
        end else if (shadow_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          slot = 0;
          while (shadow_valid[slot]) slot++;
          shadow_valid[slot] = 1'b1;
          shadow_key[slot] = k;
          shadow_val[slot] = v;
          shadow_rank[slot] = RANK_W'(shadow_count);
          shadow_count++;
          r.status = STAT_INSERTED;
        end
      end
      REQ_ERASE: begin
        if (hit >= 0) begin
          r.key = shadow_key[hit];
          r.val = shadow_val[hit];
          drop_slot(hit);
          r.status = STAT_REMOVED;
        end
      end
      REQ_POP: begin
        slot = (shadow_count == 0) ? -1 : find_rank_slot(0);
        if (slot >= 0) begin
          r.key = shadow_key[slot];
          r.val = shadow_val[slot];
          drop_slot(slot);
          r.status = STAT_REMOVED;
        end else begin
          r.status = STAT_EMPTY;
        end
      end
      REQ_LOOKUP: begin
        if (hit >= 0) begin
          r.key = shadow_key[hit];
          r.val = shadow_val[hit];
          r.status = STAT_FOUND;
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < CAPACITY; i++) shadow_valid[i] = 1'b0;
        shadow_count = 0;
        r.status = STAT_REMOVED;
      end
      REQ_READ: begin
        slot = (int'(pos) < shadow_count) ? find_rank_slot(int'(pos)) : -1;
        if (slot >= 0) begin
          r.key = shadow_key[slot];
          r.val = shadow_val[slot];
          r.status = STAT_FOUND;
        end
      end
      default: ;
    endcase
    r.count = ECNT_W'(shadow_count);
    expected_replies.insert(expected_replies.size(), r);
  endfunction

  // Queue one request word with an idle gap drawn for the current stretch
  function automatic void queue_word(input logic [REQ_W-1:0] req,
                                     input logic signed [KEY_W-1:0] k,
                                     input logic signed [VAL_W-1:0] v,
                                     input logic [POS_W-1:0] pos);
    req_word_t w;
    w.req = req;
    w.key = k;
    w.val = v;
    w.pos = pos;
    w.gap = burst_mode ? 0 : $urandom_range(0, 8);
    pending_words.insert(pending_words.size(), w);
    words_queued++;
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
    return $urandom;
  endfunction

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Driver: holds start until the word is taken, then waits the drawn gap
  always @(posedge clk) begin : drive_requests
    logic go;
    req_word_t nxt;
    go = start;
    if (rst) begin
      go = 1'b0;
      idle_cycles = 0;
    end else begin
      if (start && !busy) begin
        apply_to_shadow(req_type, key, value, position);
        words_accepted++;
        go = 1'b0;
      end
      if (!go && pending_words.size() > 0) begin
        if (idle_cycles < pending_words[0].gap) begin
          if (!busy) idle_cycles++;
        end else begin
          nxt = pending_words[0];
          pending_words.delete(0);
          req_type <= nxt.req;
          key <= nxt.key;
          value <= nxt.val;
          position <= nxt.pos;
          go = 1'b1;
          idle_cycles = 0;
        end
      end
    end
    start <= go;
  end

  // Monitor: each done pulse is checked against the oldest expected reply
  always @(posedge clk) begin : check_replies
    reply_word_t exp_r;
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        $error("result word with no request outstanding (status %0d)", status);
        errors++;
      end else begin
        exp_r = expected_replies[0];
        expected_replies.delete(0);
        replies_checked++;
        if (status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          errors++;
        end
        if (out_key !== exp_r.key) begin
          $error("out_key: expected %0d, got %0d", exp_r.key, out_key);
          errors++;
        end
        if (out_value !== exp_r.val) begin
          $error("out_value: expected %0d, got %0d", exp_r.val, out_value);
          errors++;
        end
        if (entry_count !== exp_r.count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.count, entry_count);
          errors++;
        end
        case (exp_r.status)
          STAT_FULL:    full_seen++;
          STAT_UPDATED: updated_seen++;
          STAT_FOUND:   found_seen++;
          STAT_EMPTY:   empty_seen++;
          default: ;
        endcase
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("insertion_ordered_key_value_table_unit test failed");
    $finish;
  end

  initial begin : run_test
    int pick;
    int insert_pct;
    logic [REQ_W-1:0] req;

    // Shadow table starts empty, as the design does after reset
    for (int i = 0; i < CAPACITY; i++) shadow_valid[i] = 1'b0;

    // Pool of keys so that random requests hit existing entries
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = '0;
    key_pool[3] = -1;
    for (int i = 4; i < KEY_POOL_N; i++) key_pool[i] = $urandom;

    // Directed: empty table, fill to capacity, full and update cases
    queue_word(REQ_POP, '0, '0, '0);
    for (int i = 0; i < CAPACITY; i++)
      queue_word(REQ_INSERT, key_pool[i],
                 (i == 0) ? 32'sh7fff_ffff : (i == 1) ? 32'sh8000_0000 : $urandom,
                 '0);
    queue_word(REQ_INSERT, key_pool[16], $urandom, '0);
    queue_word(REQ_INSERT, key_pool[0], '0, '0);
    queue_word(REQ_READ, '0, '0, 4'hf);
    queue_word(REQ_LOOKUP, key_pool[1], '0, '0);
    queue_word(REQ_LOOKUP, key_pool[20], '0, '0);
    queue_word(REQ_ERASE, key_pool[5], '0, '0);
    queue_word(REQ_ERASE, key_pool[5], '0, '0);
    queue_word(REQ_POP, '0, '0, '0);
    queue_word(REQ_READ, '0, '0, 4'd14);
    queue_word(REQ_RSVD_A, -1, -1, 4'hf);
    queue_word(REQ_RSVD_B, key_pool[2], '0, '0);
    queue_word(REQ_CLEAR, '0, '0, '0);

    // Random stretches with varying insert pressure and idle behavior
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 60 == 0) begin
        burst_mode = ($urandom_range(0, 3) == 0);
        insert_pct = $urandom_range(25, 65);
      end
      if ($urandom_range(0, 99) < insert_pct) begin
        req = REQ_INSERT;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 20) req = REQ_ERASE;
        else if (pick < 35) req = REQ_POP;
        else if (pick < 60) req = REQ_LOOKUP;
        else if (pick < 90) req = REQ_READ;
        else if (pick < 93) req = REQ_CLEAR;
        else req = pick[0] ? REQ_RSVD_A : REQ_RSVD_B;
      end
      queue_word(req, pick_key(), $urandom, $urandom_range(0, 15));
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (words_accepted < words_queued || expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $error("%0d expected result words never arrived", expected_replies.size());
      errors++;
    end

    $display("Checked %0d result words over %0d requests in %0d cycles.",
             replies_checked, words_accepted, cycle_count);
    $display("Seen: %0d refused as full, %0d updates, %0d found, %0d pops on empty table.",
             full_seen, updated_seen, found_seen, empty_seen);
    if (errors == 0) begin
      $display("insertion_ordered_key_value_table_unit test passed");
    end else begin
      $display("insertion_ordered_key_value_table_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/iokv_pkg.sv
design/iokv_ctrl.sv
design/iokv_store.sv
design/insertion_ordered_key_value_table_unit.sv
tb/testbench.sv
